/* design/stack_engine_with_search_sort_macros.svh */
// ----------------------------------------------------------------------------
// Stack engine assertion macros
// Shared concurrent assertion forms for the stack engine.
// ----------------------------------------------------------------------------
`ifndef STACK_ENGINE_WITH_SEARCH_SORT_MACROS_SVH
`define STACK_ENGINE_WITH_SEARCH_SORT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack engine check failed");

// next-cycle implication, disabled while reset is asserted
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack engine check failed");

`endif

/* design/sse_pkg.sv */
// ----------------------------------------------------------------------------
// Stack engine package
// Widths, operation and status codes, and the cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 7;
    localparam int DEFAULT_DEPTH = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd4;
    localparam logic [OP_W-1:0] OP_SIZE   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    // cell commands
    typedef logic [1:0] cell_cmd_t;
    localparam cell_cmd_t CELL_HOLD  = 2'd0;
    localparam cell_cmd_t CELL_DOWN  = 2'd1;  // take word from the cell above
    localparam cell_cmd_t CELL_UP    = 2'd2;  // take word from the cell below
    localparam cell_cmd_t CELL_SORT  = 2'd3;  // compare-exchange with partner

    typedef struct packed {
        cell_cmd_t cmd;
        logic      upper;  // upper member of an active pair: keeps the max
        logic      lower;  // lower member of an active pair: keeps the min
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/sse_cell.sv */
// ----------------------------------------------------------------------------
// Stack engine cell
// One stack word; shifts with its neighbors or does a compare-exchange.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sse_cell (
    input  wire logic                              clk,
    input  wire sse_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [sse_pkg::DATA_W-1:0] data_prev,
    input  wire logic signed [sse_pkg::DATA_W-1:0] data_next,
    output logic signed      [sse_pkg::DATA_W-1:0] data
);

    logic signed [sse_pkg::DATA_W-1:0] word_reg;
    logic signed [sse_pkg::DATA_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.cmd)
            sse_pkg::CELL_DOWN: word_next = data_prev;
            sse_pkg::CELL_UP:   word_next = data_next;
            sse_pkg::CELL_SORT:
            begin
                if (ctrl.upper && (data_next > word_reg))
                begin
                    word_next = data_next;
                end
                else if (ctrl.lower && (data_prev < word_reg))
                begin
                    word_next = data_prev;
                end
            end
            default:            word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign data = word_reg;

endmodule

`default_nettype wire

/* design/stack_engine_with_search_sort.sv */
// ----------------------------------------------------------------------------
// Stack engine with search and sort
// Bounded LIFO of signed words held in a chain of cells, top at cell 0.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  command   | start, busy        | op, operand_value
//  result    | done (strobe)      | status, result_value, found_position,
//            |                    | entry_count
//
//  Push, pop, peek, size and unused codes: done pulses the next cycle and a
//  new command may be taken in that same cycle.
//  Search: the whole chain rotates once past cell 0, where one comparator
//  checks each word, and ends in its original order.
//  Sort: odd-even transposition, finished like push if entry_count < 2; each
//  phase, all active pairs of that phase's parity compare-exchange in parallel.
//  Reset clears the count and control; cell contents are not cleared.
//  The result receiver cannot stall; each result is valid for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stack_engine_with_search_sort_macros.svh"

module stack_engine_with_search_sort #(
    parameter int STACK_DEPTH = sse_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [sse_pkg::OP_W-1:0]            op,
    input  wire logic signed [sse_pkg::DATA_W-1:0]   operand_value,
    output logic                                     done,
    output logic [sse_pkg::STATUS_W-1:0]             status,
    output logic signed [sse_pkg::DATA_W-1:0]        result_value,
    output logic [sse_pkg::POS_W-1:0]                found_position,
    output logic [sse_pkg::POS_W-1:0]                entry_count
);

    localparam int CW = $clog2(STACK_DEPTH + 1);  // count width
    localparam int SW = $clog2(STACK_DEPTH);      // step / phase width

    // controller states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SORT   = 2'd2;

    logic [1:0]                         state_reg,   state_next;
    logic [CW-1:0]                      count_reg,   count_next;
    logic [SW-1:0]                      step_reg,    step_next;
    logic                               found_reg,   found_next;
    logic [CW-1:0]                      pos_reg,     pos_next;
    logic signed [sse_pkg::DATA_W-1:0]  operand_reg, operand_next;
    logic                               done_reg,    done_next;
    logic [sse_pkg::STATUS_W-1:0]       status_reg,  status_next;
    logic signed [sse_pkg::DATA_W-1:0]  result_reg,  result_next;
    logic [sse_pkg::POS_W-1:0]          fpos_reg,    fpos_next;
    logic [sse_pkg::POS_W-1:0]          ecount_reg,  ecount_next;

    sse_pkg::cell_cmd_t                 cell_cmd;
    logic                               accept;
    logic [CW-1:0]                      step_ext;
    logic                               hit;

    // zero-extend then truncate: 7-bit report of a CW-bit value
    logic [CW+sse_pkg::POS_W-1:0]       count_wide;
    logic [CW+sse_pkg::POS_W-1:0]       pos_wide;

    logic signed [sse_pkg::DATA_W-1:0]  cell_q [STACK_DEPTH];

    // ------------------------------------------------------------------
    // Cell chain. Cell i holds the entry i places below the top.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < STACK_DEPTH; gi++)
    begin : g_cell
        sse_pkg::cell_ctrl_t               ctrl;
        logic                              upper_w;
        logic                              lower_w;
        logic signed [sse_pkg::DATA_W-1:0] prev_w;
        logic signed [sse_pkg::DATA_W-1:0] next_w;

        if (gi == 0)
        begin : g_head
            assign prev_w  = operand_value;   // push enters at the top
            assign lower_w = 1'b0;
        end
        else
        begin : g_body
            assign prev_w  = cell_q[gi-1];
            assign lower_w = (step_reg[0] == 1'((gi - 1) % 2))
                           && (count_reg > CW'(gi));
        end

        if (gi == STACK_DEPTH - 1)
        begin : g_tail
            assign next_w = cell_q[0];           // wrap so search rotates
        end
        else
        begin : g_inner
            assign next_w = cell_q[gi+1];
        end

        assign upper_w = (step_reg[0] == 1'(gi % 2)) && (count_reg > CW'(gi + 1));

        // packed order: cmd, upper, lower
        assign ctrl = {cell_cmd, upper_w, lower_w};

        sse_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .data_prev (prev_w),
            .data_next (next_w),
            .data      (cell_q[gi])
        );
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign step_ext = CW'(step_reg);
    assign hit      = (cell_q[0] == operand_reg) && (step_ext < count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        operand_next = operand_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        result_next  = result_reg;
        fpos_next    = fpos_reg;
        ecount_next  = ecount_reg;
        cell_cmd     = sse_pkg::CELL_HOLD;
        count_wide   = '0;
        pos_wide     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = sse_pkg::STAT_OK;
                    result_next = '0;
                    fpos_next   = '0;
                    done_next   = 1'b1;
                    unique case (op)
                        sse_pkg::OP_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                status_next = sse_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cell_cmd   = sse_pkg::CELL_DOWN;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        sse_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sse_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cell_cmd    = sse_pkg::CELL_UP;
                                count_next  = count_reg - CW'(1);
                                result_next = cell_q[0];
                            end
                        end
                        sse_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sse_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                result_next = cell_q[0];
                            end
                        end
                        sse_pkg::OP_SEARCH:
                        begin
                            done_next    = 1'b0;
                            state_next   = S_SEARCH;
                            step_next    = '0;
                            found_next   = 1'b0;
                            operand_next = operand_value;
                        end
                        sse_pkg::OP_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                done_next  = 1'b0;
                                state_next = S_SORT;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            // size and unused codes only report the count
                        end
                    endcase
                    count_wide  = {{sse_pkg::POS_W{1'b0}}, count_next};
                    ecount_next = count_wide[sse_pkg::POS_W-1:0];
                end
            end

            S_SEARCH:
            begin
                // rotate one place per cycle; cell 0 sees entry step from top
                cell_cmd  = sse_pkg::CELL_UP;
                step_next = step_reg + SW'(1);
                if (!found_reg && hit)
                begin
                    found_next = 1'b1;
                    pos_next   = step_ext + CW'(1);
                end
                if (step_reg == SW'(STACK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    result_next = '0;
                    if (found_next)
                    begin
                        status_next = sse_pkg::STAT_OK;
                        pos_wide    = {{sse_pkg::POS_W{1'b0}}, pos_next};
                        fpos_next   = pos_wide[sse_pkg::POS_W-1:0];
                    end
                    else
                    begin
                        status_next = sse_pkg::STAT_NOTFOUND;
                        fpos_next   = '0;
                    end
                    count_wide  = {{sse_pkg::POS_W{1'b0}}, count_reg};
                    ecount_next = count_wide[sse_pkg::POS_W-1:0];
                end
            end

            S_SORT:
            begin
                // odd-even transposition: phase parity is step_reg[0]
                cell_cmd  = sse_pkg::CELL_SORT;
                step_next = step_reg + SW'(1);
                if (step_ext == (count_reg - CW'(1)))
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = sse_pkg::STAT_OK;
                    result_next = '0;
                    fpos_next   = '0;
                    count_wide  = {{sse_pkg::POS_W{1'b0}}, count_reg};
                    ecount_next = count_wide[sse_pkg::POS_W-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        operand_reg <= operand_next;
        status_reg  <= status_next;
        result_reg  <= result_next;
        fpos_reg    <= fpos_next;
        ecount_reg  <= ecount_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign result_value   = result_reg;
    assign found_position = fpos_reg;
    assign entry_count    = ecount_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SSE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `SSE_ASSERT_NOW(a_done_at_finish, clk, rst_n, $fell(busy), done)
    `SSE_ASSERT_NEXT(a_push_grows, clk, rst_n,
        accept && (op == sse_pkg::OP_PUSH) && (count_reg < CW'(STACK_DEPTH)),
        count_reg == $past(count_reg) + CW'(1))
    `SSE_ASSERT_NEXT(a_walk_keeps_count, clk, rst_n, busy, count_reg == $past(count_reg))

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Stack engine testbench
// Drives push, pop, peek, search, sort and size commands and checks every
// result against a behavioral stack model kept in step with the commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import sse_pkg::*;

    localparam int PERIOD     = 8;
    localparam int DEPTH      = DEFAULT_DEPTH;
    localparam int RESET_CYC  = 12;
    // cycles with no transaction on either side before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    // op codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic [OP_W-1:0]          code;
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic [POS_W-1:0]         count;
    } stack_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [OP_W-1:0]             op;
    logic signed [DATA_W-1:0]    operand_value;
    logic                        done;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    result_value;
    logic [POS_W-1:0]            found_position;
    logic [POS_W-1:0]            entry_count;

    // model of the stack: entry 0 is the bottom, stack_fill-1 the top
    logic signed [DATA_W-1:0]    stack_model [DEPTH];
    int                          stack_fill;

    stack_result_t               pending_results [$];
    int                          error_count = 0;
    int                          idle_pct;     // chance in 100 of an idle cycle before a command
    int                          quiet_cycles = 0;

    always #(PERIOD / 2) clk = ~clk;

    stack_engine_with_search_sort #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .operand_value  (operand_value),
        .done           (done),
        .status         (status),
        .result_value   (result_value),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    // ------------------------------------------------------------------------
    // Stack model. Applies one command to the model state and returns the
    // result the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0] code,
                                                     input logic signed [DATA_W-1:0] word);
        stack_result_t            r;
        logic signed [DATA_W-1:0] held;
        int                       i;
        int                       j;
        r.code   = code;
        r.status = STAT_OK;
        r.value  = '0;
        r.pos    = '0;
        case (code)
            OP_PUSH:
                if (stack_fill >= DEPTH)
                    r.status = STAT_FULL;   // full: nothing changes
                else
                begin
                    stack_model[stack_fill] = word;
                    stack_fill++;
                end
            OP_POP:
                if (stack_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    stack_fill--;
                    r.value = stack_model[stack_fill];
                end
            OP_PEEK:
                if (stack_fill == 0)
                    r.status = STAT_EMPTY;
                else
                    r.value = stack_model[stack_fill - 1];
            OP_SEARCH:
            begin
                // first match counting down from the top, 1-based
                r.status = STAT_NOTFOUND;
                for (i = 0; i < stack_fill; i++)
                begin
                    if (stack_model[stack_fill - 1 - i] == word)
                    begin
                        r.status = STAT_OK;
                        r.pos    = POS_W'(i + 1);
                        break;
                    end
                end
            end
            OP_SORT:
                // ascending from the bottom, signed, so the largest ends on top
                for (i = 1; i < stack_fill; i++)
                begin
                    held = stack_model[i];
                    j    = i;
                    while (j > 0 && stack_model[j - 1] > held)
                    begin
                        stack_model[j] = stack_model[j - 1];
                        j--;
                    end
                    stack_model[j] = held;
                end
            default: ;  // size and the spare codes only report the count
        endcase
        r.count = POS_W'(stack_fill);
        return r;
    endfunction

    // Operand mix: small values give duplicates for search and sort,
    // extremes hit the sign boundary, the rest is full-width random.
    function automatic logic signed [DATA_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return DATA_W'($signed($urandom_range(16)) - 8);
        else if (sel < 40)
            case ($urandom_range(4))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                3:       return -1;
                default: return 1;
            endcase
        else
            return $urandom;
    endfunction

    // Search key: mostly a word that is held, so hits land at all depths.
    function automatic logic signed [DATA_W-1:0] pick_search_key();
        if (stack_fill > 0 && $urandom_range(99) < 65)
            return stack_model[$urandom_range(stack_fill - 1)];
        return pick_word();
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. Optional idle cycles first, then the command is held
    // until a rising edge sees start high and busy low; the model is updated
    // at that edge.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [OP_W-1:0] code,
                           input logic signed [DATA_W-1:0] word);
        stack_result_t exp;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start         <= 1'b0;
            op            <= OP_W'($urandom);   // junk while idle
            operand_value <= $urandom;
        end
        @(negedge clk);
        start         <= 1'b1;
        op            <= code;
        operand_value <= word;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        exp = apply_stack_op(code, word);
        pending_results.push_back(exp);
    endtask

    // ------------------------------------------------------------------------
    // Result checker. done marks a one-cycle result; the receiver cannot
    // stall, so every strobe is a transaction.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [OP_W-1:0] code,
                                        input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: op %0d %s mismatch: expected %0h, actual %0h",
                     $time, code, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        stack_result_t exp;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, actual status %0d value %0h",
                         $time, status, result_value);
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("status", exp.code, DATA_W'(exp.status), DATA_W'(status));
                check_field("result_value", exp.code, exp.value, result_value);
                check_field("found_position", exp.code, DATA_W'(exp.pos),
                            DATA_W'(found_position));
                check_field("entry_count", exp.code, DATA_W'(exp.count),
                            DATA_W'(entry_count));
            end
        end
    end

    // Watchdog: any accepted command or result clears the count.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL stack_engine_with_search_sort");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pop, peek, search and sort on an empty stack, spare codes included.
    task automatic test_empty_stack();
        send_op(OP_POP, pick_word());
        send_op(OP_PEEK, pick_word());
        send_op(OP_SEARCH, pick_word());
        send_op(OP_SORT, pick_word());
        send_op(OP_SPARE_6, WORD_MAX);
        send_op(OP_SPARE_7, WORD_MIN);
    endtask

    // Extreme words, duplicate search hit, sort across the sign boundary,
    // sort of a single entry, pop down to underflow.
    task automatic test_extreme_words();
        send_op(OP_PUSH, WORD_MAX);
        send_op(OP_PUSH, WORD_MIN);
        send_op(OP_PUSH, '0);
        send_op(OP_PUSH, -1);
        send_op(OP_PUSH, WORD_MAX);
        send_op(OP_PEEK, '0);
        send_op(OP_SEARCH, WORD_MAX);    // two copies: nearest to the top wins
        send_op(OP_SEARCH, WORD_MIN);
        send_op(OP_SEARCH, 32'sd12345);  // miss
        send_op(OP_SIZE, '0);
        send_op(OP_SORT, '0);
        send_op(OP_PEEK, '0);
        repeat (4)
            send_op(OP_POP, '0);
        send_op(OP_SORT, '0);            // one entry left
        send_op(OP_POP, '0);
        send_op(OP_POP, '0);             // underflow
    endtask

    // Fill to capacity, overflow, search as deep as the bottom entry,
    // sort a full stack, drain past empty.
    task automatic test_fill_overflow();
        while (stack_fill < DEPTH)
            send_op(OP_PUSH, pick_word());
        repeat (3)
            send_op(OP_PUSH, pick_word());
        send_op(OP_SIZE, '0);
        repeat (3)
            send_op(OP_SEARCH, pick_search_key());
        send_op(OP_SEARCH, stack_model[0]);
        send_op(OP_SORT, '0);
        send_op(OP_PEEK, '0);
        send_op(OP_SEARCH, stack_model[0]);
        while (stack_fill > 0)
            send_op(OP_POP, '0);
        send_op(OP_POP, '0);
    endtask

    // Random command mix weighted toward push so the depth wanders
    // over the whole range.
    task automatic test_random_mix(input int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 36)
                send_op(OP_PUSH, pick_word());
            else if (sel < 54)
                send_op(OP_POP, pick_word());
            else if (sel < 64)
                send_op(OP_PEEK, pick_word());
            else if (sel < 80)
                send_op(OP_SEARCH, pick_search_key());
            else if (sel < 87)
                send_op(OP_SORT, pick_word());
            else if (sel < 93)
                send_op(OP_SIZE, pick_word());
            else if (sel < 97)
                send_op(OP_SPARE_6, pick_word());
            else
                send_op(OP_SPARE_7, pick_word());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_SIZE;
        operand_value = '0;
        stack_fill    = 0;
        idle_pct      = 0;
        repeat (RESET_CYC)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_extreme_words();

        // back-to-back commands
        idle_pct = 0;
        test_fill_overflow();
        test_random_mix(90);

        // sender mostly idle
        idle_pct = 83;
        test_random_mix(90);

        // result side never stalls, so the mixed phase only idles the sender
        idle_pct = 35;
        test_fill_overflow();
        test_random_mix(90);

        idle_pct = 0;
        test_random_mix(80);

        @(negedge clk);
        start <= 1'b0;

        // drain, then watch a quiet window for stray strobes
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH)
            @(posedge clk);

        if (error_count == 0)
            $display("PASS stack_engine_with_search_sort");
        else
            $display("FAIL stack_engine_with_search_sort");
        $finish;
    end

endmodule
